// ===== rtl/qewt_pkg.sv =====
`timescale 1ns / 1ps

package qewt_pkg;

   // Field widths of the request and response channels
   localparam int CHAR_W       = 8;
   localparam int TOKENS_W     = 7;
   localparam int INDEX_W      = 6;
   localparam int STATUS_W     = 3;

   // Defaults for the top-level parameters and the register
   localparam int MAX_SLOTS_DEF = 64;
   localparam logic [TOKENS_W-1:0] MAX_TOKENS_RST = 7'd16;

   // Depth of the queue between front and back (power of two)
   localparam int QUEUE_DEPTH  = 4;

   // One classified request as it travels through the queue
   typedef struct packed {
      logic [CHAR_W-1:0] in_char;
      logic              is_last;
      logic              is_ws;
      logic              is_quote;
      logic              is_bslash;
   } entry_type;

endpackage

// ===== rtl/quoted_escaped_word_tokenizer.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  in_char[7:0], is_last
// rsp_      out        rsp_valid / rsp_stall  char_valid, out_char[7:0], word_index[5:0],
//                                             word_kept, word_end, line_end,
//                                             line_status[2:0], words_kept[6:0]
// csr_      in         csr_wr_en              csr_wr_data[6:0] = max_tokens
//
// One request per cycle sustained while rsp_stall is low, set by the mode/escape/count
// update. A request is written into a queue slot and is then loaded into the parser's
// output register, which drives rsp_.
// Reset is synchronous: parser in scan mode, no words, max_tokens = 16.
// rsp_stall holds the output register; the four-entry queue takes requests
// until full, then req_stall rises.

module quoted_escaped_word_tokenizer #(
   parameter int MAX_SLOTS = qewt_pkg::MAX_SLOTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [qewt_pkg::CHAR_W-1:0]    req_in_char,
   input  logic                           req_is_last,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_char_valid,
   output logic [qewt_pkg::CHAR_W-1:0]    rsp_out_char,
   output logic [qewt_pkg::INDEX_W-1:0]   rsp_word_index,
   output logic                           rsp_word_kept,
   output logic                           rsp_word_end,
   output logic                           rsp_line_end,
   output logic [qewt_pkg::STATUS_W-1:0]  rsp_line_status,
   output logic [qewt_pkg::TOKENS_W-1:0]  rsp_words_kept,
   input  logic                           csr_wr_en,
   input  logic [qewt_pkg::TOKENS_W-1:0]  csr_wr_data
);

   qewt_pkg::entry_type front_entry;
   qewt_pkg::entry_type q_head;
   logic                q_full;
   logic                q_empty;
   logic                q_pop;

   // Front: tag each request as whitespace, quote or backslash
   qewt_front u_front (
      .in_char (req_in_char),
      .is_last (req_is_last),
      .entry   (front_entry)
   );

   // Stall the request side only when the queue is full
   assign req_stall = q_full;

   // Queue decouples the request side from the parser
   qewt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_entry (front_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   // Back: run the parser state and hold the response register
   qewt_back #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_char_valid  (rsp_char_valid),
      .rsp_out_char    (rsp_out_char),
      .rsp_word_index  (rsp_word_index),
      .rsp_word_kept   (rsp_word_kept),
      .rsp_word_end    (rsp_word_end),
      .rsp_line_end    (rsp_line_end),
      .rsp_line_status (rsp_line_status),
      .rsp_words_kept  (rsp_words_kept)
   );

endmodule

// ===== rtl/qewt_front.sv =====
`timescale 1ns / 1ps

module qewt_front (
   input  logic [qewt_pkg::CHAR_W-1:0] in_char,
   input  logic                        is_last,
   output qewt_pkg::entry_type         entry
);

   localparam logic [qewt_pkg::CHAR_W-1:0] CH_QUOTE  = 8'h22;
   localparam logic [qewt_pkg::CHAR_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [qewt_pkg::CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [qewt_pkg::CHAR_W-1:0] CH_TAB    = 8'h09;
   localparam logic [qewt_pkg::CHAR_W-1:0] CH_CR     = 8'h0D;

   // Classify: space, tab through carriage return are whitespace
   always_comb begin
      entry.in_char   = in_char;
      entry.is_last   = is_last;
      entry.is_ws     = (in_char == CH_SPACE) || ((in_char >= CH_TAB) && (in_char <= CH_CR));
      entry.is_quote  = (in_char == CH_QUOTE);
      entry.is_bslash = (in_char == CH_BSLASH);
   end

endmodule

// ===== rtl/qewt_queue.sv =====
`timescale 1ns / 1ps

module qewt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  qewt_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output qewt_pkg::entry_type head
);

   localparam int DEPTH = qewt_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   qewt_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/qewt_back.sv =====
`timescale 1ns / 1ps

module qewt_back #(
   parameter int MAX_SLOTS = qewt_pkg::MAX_SLOTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [qewt_pkg::TOKENS_W-1:0]  csr_wr_data,
   input  logic                           q_empty,
   input  qewt_pkg::entry_type            q_head,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_char_valid,
   output logic [qewt_pkg::CHAR_W-1:0]    rsp_out_char,
   output logic [qewt_pkg::INDEX_W-1:0]   rsp_word_index,
   output logic                           rsp_word_kept,
   output logic                           rsp_word_end,
   output logic                           rsp_line_end,
   output logic [qewt_pkg::STATUS_W-1:0]  rsp_line_status,
   output logic [qewt_pkg::TOKENS_W-1:0]  rsp_words_kept
);

   localparam int TW = qewt_pkg::TOKENS_W;
   localparam int IW = qewt_pkg::INDEX_W;
   localparam logic [TW-1:0] SLOTS     = TW'(MAX_SLOTS);
   localparam logic [TW-1:0] CNT_SAT   = {TW{1'b1}};
   localparam logic [TW-1:0] INDEX_SAT = TW'({IW{1'b1}});

   typedef enum logic [1:0] {
      MODE_SCAN   = 2'd0,
      MODE_QUOTED = 2'd1,
      MODE_BARE   = 2'd2
   } mode_type;

   typedef enum logic [qewt_pkg::STATUS_W-1:0] {
      ST_BUSY     = 3'd0,
      ST_OK       = 3'd1,
      ST_BSLASH   = 3'd2,
      ST_UNQUOTED = 3'd3,
      ST_NO_WORDS = 3'd4
   } status_type;

   mode_type        mode_ff, mode_in;
   logic            esc_ff, esc_in;
   logic [TW-1:0]   count_ff, count_in;
   logic [TW-1:0]   max_ff;
   logic [TW-1:0]   eff;
   logic [TW-1:0]   kept_count;
   logic            take;
   logic            cv, wend, bs_end;
   status_type      status;

   logic                          rsp_valid_ff;
   logic                          char_valid_ff;
   logic [qewt_pkg::CHAR_W-1:0]   out_char_ff;
   logic [IW-1:0]                 word_index_ff;
   logic                          word_kept_ff;
   logic                          word_end_ff;
   logic                          line_end_ff;
   status_type                    line_status_ff;
   logic [TW-1:0]                 words_kept_ff;

   // Take the head when the output register is free or being drained
   assign take  = !q_empty && (!rsp_valid_ff || !rsp_stall);
   assign q_pop = take;
   assign eff   = (max_ff > SLOTS) ? SLOTS : max_ff;

   always_comb begin
      cv      = 1'b0;
      wend    = 1'b0;
      bs_end  = 1'b0;
      mode_in = mode_ff;
      esc_in  = esc_ff;
      if (esc_ff) begin
         cv     = 1'b1;
         esc_in = 1'b0;
      end else begin
         unique case (mode_ff)
            MODE_QUOTED: begin
               if (q_head.is_quote) begin
                  wend    = 1'b1;
                  mode_in = MODE_SCAN;
               end else if (q_head.is_bslash) begin
                  if (q_head.is_last) bs_end = 1'b1;
                  else esc_in = 1'b1;
               end else begin
                  cv = 1'b1;
               end
            end
            MODE_BARE: begin
               if (q_head.is_bslash) begin
                  if (q_head.is_last) bs_end = 1'b1;
                  else esc_in = 1'b1;
               end else if (q_head.is_ws) begin
                  wend    = 1'b1;
                  mode_in = MODE_SCAN;
               end else begin
                  cv = 1'b1;
               end
            end
            default: begin
               mode_in = MODE_SCAN;
               if (q_head.is_quote) begin
                  mode_in = MODE_QUOTED;
               end else if (q_head.is_ws) begin
                  mode_in = MODE_SCAN;
               end else if (q_head.is_bslash) begin
                  if (q_head.is_last) begin
                     bs_end = 1'b1;
                  end else begin
                     mode_in = MODE_BARE;
                     esc_in  = 1'b1;
                  end
               end else begin
                  mode_in = MODE_BARE;
                  cv      = 1'b1;
               end
            end
         endcase
      end

      // Close a bare word at line end unless a dangling backslash ate it
      if (q_head.is_last && !bs_end && (mode_in == MODE_BARE)) wend = 1'b1;

      count_in   = (wend && (count_ff != CNT_SAT)) ? count_ff + TW'(1) : count_ff;
      kept_count = (count_in < eff) ? count_in : eff;

      priority if (!q_head.is_last)        status = ST_BUSY;
      else if (bs_end)                     status = ST_BSLASH;
      else if (mode_in == MODE_QUOTED)     status = ST_UNQUOTED;
      else if (kept_count == '0)           status = ST_NO_WORDS;
      else                                 status = ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= qewt_pkg::MAX_TOKENS_RST;
      end else if (csr_wr_en) begin
         max_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_SCAN;
         esc_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            rsp_valid_ff   <= 1'b1;
            char_valid_ff  <= cv;
            out_char_ff    <= cv ? q_head.in_char : '0;
            word_index_ff  <= (count_ff > INDEX_SAT) ? {IW{1'b1}} : count_ff[IW-1:0];
            word_kept_ff   <= (count_ff < eff);
            word_end_ff    <= wend;
            line_end_ff    <= q_head.is_last;
            line_status_ff <= status;
            words_kept_ff  <= kept_count;
            if (q_head.is_last) begin
               mode_ff  <= MODE_SCAN;
               esc_ff   <= 1'b0;
               count_ff <= '0;
            end else begin
               mode_ff  <= mode_in;
               esc_ff   <= esc_in;
               count_ff <= count_in;
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_char_valid  = char_valid_ff;
   assign rsp_out_char    = out_char_ff;
   assign rsp_word_index  = word_index_ff;
   assign rsp_word_kept   = word_kept_ff;
   assign rsp_word_end    = word_end_ff;
   assign rsp_line_end    = line_end_ff;
   assign rsp_line_status = line_status_ff;
   assign rsp_words_kept  = words_kept_ff;

   a_status_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (line_status_ff != ST_BUSY) |-> line_end_ff)
      else $error("line status reported away from line end");

   a_char_zeroed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !char_valid_ff |-> (out_char_ff == '0))
      else $error("non-word character not cleared");

   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (words_kept_ff <= SLOTS))
      else $error("kept word count beyond slot count");

   a_line_restart: assert property (@(posedge clock) disable iff (reset)
      take && q_head.is_last |=> (count_ff == '0) && !esc_ff && (mode_ff == MODE_SCAN))
      else $error("parser state not cleared after line end");

endmodule
